>>> rtl/core/sha256_byte_stream_hasher_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher assertion macros
// Shared concurrent assertion forms used by the hasher's modules.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBSH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, constants and round functions shared by the hasher's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbsh_pkg;

   typedef logic [31:0] word_type;

   localparam int FillWidth     = 6;
   localparam int RoundWidth    = 6;
   localparam int WordIdxWidth  = 3;
   localparam int DigestWords   = 8;
   localparam int WindowWords   = 16;
   localparam int LengthWidth   = 64;

   localparam logic [FillWidth-1:0]    LengthOffset = 6'd56;
   localparam logic [FillWidth-1:0]    LastFill     = 6'd63;
   localparam logic [RoundWidth-1:0]   LastRound    = 6'd63;
   localparam logic [WordIdxWidth-1:0] LastWord     = 3'd7;
   localparam logic [7:0]              PadByte      = 8'h80;
   localparam logic [LengthWidth-1:0]  BitsPerByte  = 64'd8;

   localparam int QueuePtrWidth = 1;
   localparam int QueueDepth    = 1 << QueuePtrWidth;
   localparam logic [QueuePtrWidth:0] QueueFull = (QueuePtrWidth + 1)'(QueueDepth);

   localparam word_type InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [0:0] {
      CMD_DATA,
      CMD_FINISH
   } cmd_type;

   // Head of the command queue as seen by the engine.
   typedef struct packed {
      logic       valid;
      cmd_type    cmd;
      logic [7:0] data;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

>>> rtl/core/sbsh_channels.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher channels
// Valid/ready interfaces for the byte request and digest response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbsh_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

>>> rtl/core/sbsh_front.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts request beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_macros.svh"

module sbsh_front (
   input  logic                    clock,
   input  logic                    reset,
   sbsh_req_if.sink                req,
   output sbsh_pkg::queue_head_type head,
   input  logic                    pop
);
   import sbsh_pkg::*;

   cmd_type                 q_cmd_ff  [QueueDepth];
   logic [7:0]              q_data_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   count_ff, count_in;
   logic                    push;
   cmd_type                 cmd_in;

   assign req.ready = (count_ff != QueueFull);
   assign push      = req.valid && req.ready;
   assign cmd_in    = req.kind ? CMD_FINISH : CMD_DATA;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_cmd_ff[rd_ptr_ff];
   assign head.data  = q_data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]  <= cmd_in;
         q_data_ff[wr_ptr_ff] <= req.data_byte;
      end
   end

   `SBSH_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= QueueFull, "queue overfilled")

endmodule

>>> rtl/core/sbsh_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher engine
// Assembles the block, pads the message, runs one round per cycle and
// returns the digest words through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_macros.svh"

module sbsh_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  sbsh_pkg::queue_head_type head,
   output logic                     pop,
   sbsh_rsp_if.source               rsp
);
   import sbsh_pkg::*;

   state_type               state_ff, state_in;
   logic [FillWidth-1:0]    fill_ff, fill_in;
   logic [LengthWidth-1:0]  bits_ff, bits_in;
   logic [LengthWidth-1:0]  len_ff, len_in;
   logic                    pad_ff, pad_in;
   logic                    fin_ff, fin_in;
   logic [RoundWidth-1:0]   round_ff, round_in;
   logic [WordIdxWidth-1:0] idx_ff, idx_in;
   logic [23:0]             acc_ff, acc_in;
   word_type                win_ff  [WindowWords];
   word_type                win_in  [WindowWords];
   word_type                work_ff [DigestWords];
   word_type                work_in [DigestWords];
   word_type                hash_ff [DigestWords];
   word_type                hash_in [DigestWords];
   logic                    rsp_valid_ff, rsp_valid_in;
   word_type                rsp_word_ff, rsp_word_in;
   logic [WordIdxWidth-1:0] rsp_idx_ff, rsp_idx_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic       put_en;
   logic [7:0] put_byte;
   logic       block_full;
   logic       emit_load;
   word_type   t1;
   word_type   t2;
   word_type   next_w;

   assign block_full = put_en && (fill_ff == LastFill);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (block_full) begin
                  state_in = ST_ROUND;
               end else if (head.cmd == CMD_FINISH) begin
                  state_in = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_ZERO: begin
            if (fill_ff == LengthOffset) begin
               state_in = ST_PAD_LEN;
            end else if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_PAD_LEN: begin
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LastRound) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            priority if (fin_ff) begin
               state_in = ST_EMIT;
            end else if (pad_ff) begin
               state_in = ST_PAD_ZERO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_load && idx_ff == LastWord) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: the queue pop, which byte goes into the block this cycle and the digest load.
   always_comb begin
      pop       = 1'b0;
      put_en    = 1'b0;
      put_byte  = 8'h00;
      emit_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               put_en   = 1'b1;
               put_byte = (head.cmd == CMD_DATA) ? head.data : PadByte;
            end
         end
         ST_PAD_ZERO: begin
            put_en = (fill_ff != LengthOffset);
         end
         ST_PAD_LEN: begin
            put_en   = 1'b1;
            put_byte = len_ff[LengthWidth-1 -: 8];
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            put_en = 1'b0;
         end
      endcase
   end

   // One compression round and the message schedule step.
   always_comb begin
      t1 = work_ff[7] + big_sigma1(work_ff[4])
         + choose(work_ff[4], work_ff[5], work_ff[6]) + RoundK[round_ff] + win_ff[0];
      t2 = big_sigma0(work_ff[0]) + majority(work_ff[0], work_ff[1], work_ff[2]);
      next_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   end

   always_comb begin
      fill_in      = put_en ? fill_ff + 1'b1 : fill_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      fin_in       = fin_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      win_in       = win_ff;
      work_in      = work_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      if (pop) begin
         if (head.cmd == CMD_DATA) begin
            bits_in = bits_ff + BitsPerByte;
         end else begin
            // The length field takes the count before this message ends.
            len_in  = bits_ff;
            bits_in = '0;
            pad_in  = 1'b1;
         end
      end

      if (state_ff == ST_PAD_LEN) begin
         len_in = {len_ff[LengthWidth-9:0], 8'h00};
         if (block_full) begin
            fin_in = 1'b1;
         end
      end

      if (put_en) begin
         acc_in = {acc_ff[15:0], put_byte};
         // Every fourth byte completes a big-endian word of the schedule.
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < WindowWords - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WindowWords-1] = {acc_ff, put_byte};
         end
      end

      if (block_full) begin
         work_in  = hash_ff;
         round_in = '0;
      end

      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < WindowWords - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WindowWords-1] = next_w;
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
         round_in   = round_ff + 1'b1;
      end

      if (state_ff == ST_UPDATE) begin
         for (int i = 0; i < DigestWords; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end

      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = hash_ff[idx_ff];
         rsp_idx_in   = idx_ff;
         rsp_last_in  = (idx_ff == LastWord);
         idx_in       = idx_ff + 1'b1;
         if (idx_ff == LastWord) begin
            hash_in = InitHash;
            pad_in  = 1'b0;
            fin_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         pad_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hash_ff      <= InitHash;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         pad_ff       <= pad_in;
         fin_ff       <= fin_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      round_ff    <= round_in;
      acc_ff      <= acc_in;
      win_ff      <= win_in;
      work_ff     <= work_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.digest_word = rsp_word_ff;
   assign rsp.word_index  = rsp_idx_ff;
   assign rsp.last_word   = rsp_last_ff;

   `SBSH_ASSERT_NOW(a_pop_valid, clock, reset, pop, head.valid, "pop from an empty queue")
   `SBSH_ASSERT_NEXT(a_round_end, clock, reset, state_ff == ST_ROUND && round_ff == LastRound, state_ff == ST_UPDATE, "rounds did not end in update")
   `SBSH_ASSERT_NOW(a_emit_aligned, clock, reset, state_ff == ST_EMIT, fill_ff == '0, "digest emitted with a partial block")
   `SBSH_ASSERT_NOW(a_len_tail, clock, reset, state_ff == ST_PAD_LEN, fill_ff >= LengthOffset, "length bytes outside the block tail")

endmodule

>>> rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the 256-bit digest as eight beats.
// ----------------------------------------------------------------------------
// Request channel: one beat per message byte (kind 0) or one finish beat
// (kind 1). A two-entry queue takes beats while the engine is busy.
// Response channel: a finish beat yields eight beats, digest word 0 first,
// with last_word set on the eighth.
// Data bytes enter the block in the idle state; every 64th byte also starts
// the compression, one round per cycle, 64 rounds and then an update step
// that folds the result into the hash. A finish beat pads the block one
// byte per cycle, with an idle step at the length offset before the
// length bytes, runs one or two compressions and then loads the eight
// digest words into the output register, one per cycle while the
// receiver takes them. Reset loads the initial hash values, empties the
// queue and clears the fill, bit and word counters of the engine.
// When the receiver stalls, the engine waits with the next digest word and
// the queue fills; ready on the request channel then drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
   input logic        clock,
   input logic        reset,
   sbsh_req_if.sink   req_ch,
   sbsh_rsp_if.source rsp_ch
);
   import sbsh_pkg::*;

   queue_head_type head;
   logic           pop;

   sbsh_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .head  (head),
      .pop   (pop)
   );

   sbsh_engine u_engine (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule
